[sv/int_to_decimal_ascii_defines.svh]
// assertion macros for the decimal text converter
`ifndef INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
`define ITDA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITDA_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITDA_ASSERT(label, clk, rst_n, prop, msg)
`define ITDA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/itda_pkg.sv]
// ----------------------------------------------------------------------------
// itda_pkg
// shared types and constants of the decimal text converter
// ----------------------------------------------------------------------------
package itda_pkg;
	localparam int MAX_WIDTH_DEF = 64;
	localparam int MAX_DIGITS    = 20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	typedef enum logic [1:0] {
		WSEL_8  = 2'd0,
		WSEL_16 = 2'd1,
		WSEL_32 = 2'd2,
		WSEL_64 = 2'd3
	} wsel_t;

	typedef struct packed {
		logic [63:0] number_bits;
		logic [1:0]  width_sel;
		logic        is_signed;
		logic [7:0]  capacity;
	} in_item_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       last_char;
		logic [4:0] text_length;
		logic       too_long;
	} out_item_t;

	// converted item passed from the digit pipeline to the serializer
	typedef struct packed {
		logic [MAX_DIGITS-1:0][3:0] digits;
		logic [4:0] ndig;
		logic       neg;
		logic       fail;
	} conv_t;
endpackage

[sv/itda_if.sv]
// ----------------------------------------------------------------------------
// itda_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface itda_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/itda_conv.sv]
// ----------------------------------------------------------------------------
// itda_conv
// pipeline: magnitude, then double-dabble in stages of eight bits, then count
// ----------------------------------------------------------------------------
module itda_conv
	import itda_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output conv_t     out_item
);
	localparam int NST = 8;            // bcd stages, eight bits each
	localparam int BW  = MAX_DIGITS * 4;

	// stage 0: magnitude
	logic [63:0] mag_s0;
	logic [7:0]  cap_s0;
	logic        neg_s0;
	logic        v_s0;

	// stage k: bcd accumulator and remaining bits
	logic [NST:0][BW-1:0] bcd_s;
	logic [NST:0][63:0]   sh_s;
	logic [NST:0][7:0]    cap_s;
	logic [NST:0]         neg_s;
	logic [NST:0]         v_s;

	logic [NST+1:0] adv;

	// final stage
	logic  v_sf;
	conv_t item_sf;

	always_comb begin
		adv[NST+1] = !v_sf || out_ready;
		for (int k = NST; k >= 0; k--) begin
			adv[k] = !v_s[k] || adv[k+1];
		end
	end
	assign in_ready = !v_s0 || adv[0];

	logic [63:0] mask;
	logic [63:0] raw;
	logic        sgn;
	logic [63:0] magc;
	always_comb begin
		logic [6:0] w;
		unique case (wsel_t'(in_item.width_sel))
			WSEL_8:  w = 7'd8;
			WSEL_16: w = 7'd16;
			WSEL_32: w = 7'd32;
			default: w = 7'd64;
		endcase
		if (w > 7'(MAX_WIDTH)) w = 7'(MAX_WIDTH);
		mask = (w >= 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
		raw  = in_item.number_bits & mask;
		sgn  = in_item.is_signed && raw[6'(w - 7'd1)];
		magc = sgn ? ((~raw + 64'd1) & mask) : raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (in_ready) begin
			v_s0 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mag_s0 <= magc;
			cap_s0 <= in_item.capacity;
			neg_s0 <= sgn;
		end
	end

	// bcd pipeline, stage k consumes bits from the top of sh
	for (genvar k = 0; k <= NST; k++) begin : g_st
		logic [BW-1:0] bi;
		logic [63:0]   si;
		logic [7:0]    ci;
		logic          ni;
		logic          vi;
		logic [BW-1:0] bo;
		if (k == 0) begin : g_first
			assign bi = '0;
			assign si = mag_s0;
			assign ci = cap_s0;
			assign ni = neg_s0;
			assign vi = v_s0;
		end else begin : g_next
			assign bi = bcd_s[k-1];
			assign si = sh_s[k-1];
			assign ci = cap_s[k-1];
			assign ni = neg_s[k-1];
			assign vi = v_s[k-1];
		end
		always_comb begin
			bo = bi;
			if (k < NST) begin
				for (int b = 0; b < 8; b++) begin
					for (int d = 0; d < MAX_DIGITS; d++) begin
						if (bo[d*4 +: 4] >= 4'd5) bo[d*4 +: 4] = bo[d*4 +: 4] + 4'd3;
					end
					bo = {bo[BW-2:0], si[63-b]};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				v_s[k] <= vi;
			end
		end
		always_ff @(posedge clk) begin
			if (adv[k] && vi) begin
				bcd_s[k] <= bo;
				sh_s[k]  <= (k < NST) ? {si[55:0], 8'd0} : si;
				cap_s[k] <= ci;
				neg_s[k] <= ni;
			end
		end
	end

	// digit count and capacity check
	conv_t itc;
	always_comb begin
		logic [4:0] nd;
		nd = 5'd1;
		for (int d = 1; d < MAX_DIGITS; d++) begin
			if (bcd_s[NST][d*4 +: 4] != 4'd0) nd = 5'(d + 1);
		end
		itc.digits = bcd_s[NST];
		itc.ndig   = nd;
		itc.neg    = neg_s[NST];
		itc.fail   = {3'd0, nd} > cap_s[NST];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (adv[NST+1]) begin
			v_sf <= v_s[NST];
		end
	end
	always_ff @(posedge clk) begin
		if (adv[NST+1] && v_s[NST]) item_sf <= itc;
	end

	assign out_valid = v_sf;
	assign out_item  = item_sf;
endmodule

[sv/itda_ser.sv]
// ----------------------------------------------------------------------------
// itda_ser
// emits one character per cycle while the receiver is ready, most significant first
// ----------------------------------------------------------------------------
module itda_ser
	import itda_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  conv_t     in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
`include "int_to_decimal_ascii_defines.svh"
	conv_t      cur_q;
	logic       busy_q;
	logic       sign_q;   // minus still to send
	logic [4:0] idx_q;    // next digit index plus one
	logic       ov_q;
	out_item_t  ob_q;

	logic take_out;
	logic done_next;
	out_item_t nx;

	assign take_out = !ov_q || out_ready;
	assign in_ready = !busy_q || (take_out && done_next);

	always_comb begin
		logic [4:0] tot;
		tot = cur_q.ndig + {4'd0, cur_q.neg};
		nx.too_long    = cur_q.fail;
		nx.text_length = cur_q.fail ? 5'd0 : tot;
		if (cur_q.fail) begin
			nx.ascii_char = 8'd0;
			nx.last_char  = 1'b1;
			done_next     = 1'b1;
		end else if (sign_q) begin
			nx.ascii_char = CHAR_MINUS;
			nx.last_char  = 1'b0;
			done_next     = 1'b0;
		end else begin
			nx.ascii_char = CHAR_ZERO + {4'd0, cur_q.digits[idx_q - 5'd1]};
			nx.last_char  = idx_q == 5'd1;
			done_next     = idx_q == 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (take_out) ov_q <= busy_q;
			if (in_ready) begin
				busy_q <= in_valid;
				sign_q <= in_item.neg;
				idx_q  <= in_item.ndig;
			end else if (busy_q && take_out) begin
				if (sign_q) sign_q <= 1'b0;
				else idx_q <= idx_q - 5'd1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) cur_q <= in_item;
		if (take_out && busy_q) ob_q <= nx;
	end

	assign out_valid = ov_q;
	assign out_item  = ob_q;

	`ITDA_ASSERT(a_fail_len, clk, arst_n, ov_q && ob_q.too_long |-> ob_q.last_char && ob_q.text_length == 5'd0, "failure result malformed")
	`ITDA_ASSERT(a_hold, clk, arst_n, ov_q && !out_ready |=> ov_q && $stable(ob_q), "stalled result changed")
	`ITDA_ASSERT(a_idx, clk, arst_n, busy_q && !cur_q.fail && !sign_q |-> idx_q != 5'd0, "digit index out of range")
endmodule

[sv/int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// integer to decimal text, one character per output transaction
// ----------------------------------------------------------------------------
// An item passes eleven pipeline registers to convert (magnitude, eight
// double-dabble stages of eight bits, one hold stage, digit count) and two in
// the character serializer. It then leaves as one character per cycle while
// the receiver is ready: a conversion occupies the output for its text length
// (1 to 20 characters, one on failure), which sets the sustained rate;
// conversions overlap in the pipeline behind the character serializer and
// follow each other on the output with no gap.
module int_to_decimal_ascii
	import itda_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	itda_if.sink   in_ch,
	itda_if.source out_ch
);
	logic  cv_valid;
	logic  cv_ready;
	conv_t cv_item;

	itda_conv #(.MAX_WIDTH(MAX_WIDTH)) u_conv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.data),
		.out_valid(cv_valid), .out_ready(cv_ready), .out_item(cv_item)
	);

	itda_ser u_ser (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cv_valid), .in_ready(cv_ready), .in_item(cv_item),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.data)
	);
endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives integers of every width and signedness into the decimal text
// converter and checks each character against a predicted text queue
// ----------------------------------------------------------------------------
module testbench;
	import itda_pkg::*;

	logic clk;
	logic arst_n;
	bit failed;
	bit hold_off;
	bit stall_on;
	int unsigned cycles;

	itda_if #(.payload_t(in_item_t))  in_ch ();
	itda_if #(.payload_t(out_item_t)) out_ch ();

	out_item_t text_queue[$];

	int_to_decimal_ascii DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// expected characters of one conversion
	task automatic predict_text(input in_item_t item);
		int unsigned w;
		logic [63:0] mask;
		logic [63:0] raw;
		logic [63:0] mag;
		bit neg;
		logic [7:0] digs[$];
		int unsigned total;
		out_item_t r;
		case (wsel_t'(item.width_sel))
			WSEL_8:  w = 8;
			WSEL_16: w = 16;
			WSEL_32: w = 32;
			default: w = 64;
		endcase
		mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
		raw = item.number_bits & mask;
		neg = item.is_signed && raw[w-1];
		mag = neg ? ((~raw + 64'd1) & mask) : raw;
		do begin
			digs.push_front(CHAR_ZERO + 8'(mag % 64'd10));
			mag = mag / 64'd10;
		end while (mag != 0);
		if (digs.size() > item.capacity) begin
			r = '{ascii_char: 8'd0, last_char: 1'b1, text_length: 5'd0, too_long: 1'b1};
			text_queue.push_back(r);
			return;
		end
		total = digs.size() + (neg ? 1 : 0);
		if (neg)
			digs.push_front(CHAR_MINUS);
		foreach (digs[i]) begin
			r.ascii_char  = digs[i];
			r.last_char   = (i == digs.size() - 1);
			r.text_length = 5'(total);
			r.too_long    = 1'b0;
			text_queue.push_back(r);
		end
	endtask

	// offer one item, wait for acceptance; valid stays up for a following item
	task automatic send_number(input logic [63:0] num, input wsel_t ws, input bit sg,
			input logic [7:0] cap);
		in_item_t item;
		item = '{number_bits: num, width_sel: ws, is_signed: sg, capacity: cap};
		in_ch.valid <= 1'b1;
		in_ch.data  <= item;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_text(item);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// value with random digit count: small magnitudes often
	function automatic logic [63:0] rand_number();
		case ($urandom_range(0, 3))
			0: return 64'($urandom_range(0, 20));
			1: return rand64() >> $urandom_range(0, 63);
			2: return ~(rand64() >> $urandom_range(0, 63));
			default: return rand64();
		endcase
	endfunction

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (text_queue.size() != 0)
			@(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	task automatic test_extremes();
		wsel_t ws;
		for (int k = 0; k < 4; k++) begin
			ws = wsel_t'(k);
			send_number(64'd0, ws, 1'b0, 8'd255);
			send_number('1, ws, 1'b0, 8'd255);
			send_number('1, ws, 1'b1, 8'd255);
			send_number(64'd1 << ((8 << k) - 1), ws, 1'b1, 8'd255);
			send_number((64'd1 << ((8 << k) - 1)) - 1, ws, 1'b1, 8'd20);
		end
		send_number(64'd5, WSEL_8, 1'b0, 8'd0);
		send_number(64'hff, WSEL_8, 1'b1, 8'd1);
		send_number(64'hff, WSEL_8, 1'b1, 8'd0);
		send_number(64'hffff_ffff_ffff_ff80, WSEL_8, 1'b1, 8'd2);
		send_number(64'd100, WSEL_8, 1'b0, 8'd3);
		wait_drained();
	endtask

	task automatic test_random_bursts(input int n);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < n; b++) begin
				send_number(rand_number(), wsel_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0) ?
					8'($urandom()) : 8'($urandom_range(0, 21)));
				sent++;
			end
			if ($urandom_range(0, 2) == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	endtask

	// receiver holds off long enough that the pipeline fills and stalls intake
	task automatic test_backpressure();
		hold_off = 1'b1;
		test_random_bursts(30);
		hold_off = 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_backpressure();
		stall_on = 1'b1;
		test_random_bursts(200);
		wait_drained();
		stall_on = 1'b0;
		test_random_bursts(200);
		wait_drained();
		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver stall pattern; long hold counted in its own process
	int unsigned held;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			held <= 0;
		end else if (hold_off && held < 600) begin
			out_ch.ready <= 1'b0;
			held <= held + 1;
		end else if (stall_on) begin
			out_ch.ready <= ($urandom_range(0, 9) < 6);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (text_queue.size() == 0) begin
				$display("%0t: unexpected character, actual %p", $time, out_ch.data);
				failed = 1'b1;
			end else begin
				exp_r = text_queue.pop_front();
				if (out_ch.data !== exp_r) begin
					$display("%0t: mismatch, expected %p actual %p", $time, exp_r,
						out_ch.data);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end
endmodule
